[sv/cbls_pkg.sv]
// shared types, character codes and helpers for the chunked body length scanner
package cbls_pkg;

  localparam logic [7:0]  CHAR_CR    = 8'h0D;
  localparam logic [7:0]  CHAR_LF    = 8'h0A;
  localparam logic [7:0]  CHAR_SP    = 8'h20;
  localparam logic [7:0]  CHAR_TAB   = 8'h09;
  localparam logic [7:0]  CHAR_SEMI  = 8'h3B;
  localparam logic [7:0]  CHAR_COLON = 8'h3A;
  localparam logic [7:0]  CHAR_D0    = 8'h30;
  localparam logic [7:0]  CHAR_D9    = 8'h39;
  localparam logic [7:0]  CHAR_UA    = 8'h41;
  localparam logic [7:0]  CHAR_UF    = 8'h46;
  localparam logic [7:0]  CHAR_LA    = 8'h61;
  localparam logic [7:0]  CHAR_LF_HEX = 8'h66;
  localparam logic [31:0] LEN_MAX    = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    V_MORE = 2'd0,
    V_DONE = 2'd1,
    V_BAD  = 2'd2
  } verdict_e;

  typedef enum logic [5:0] {
    PH_SIZE    = 6'b000001,
    PH_DATA    = 6'b000010,
    PH_DCR     = 6'b000100,
    PH_DLF     = 6'b001000,
    PH_TRAILER = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_e;

  typedef struct packed {
    logic digit;
    logic tblank;
    logic ext;
    logic cr;
    logic nonempty;
    logic colon;
  } line_flags_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       start_flag;
  } item_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [31:0] total_length;
  } result_t;

  // {is_hex, digit value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] v;
    logic       ok;
    v  = '0;
    ok = 1'b0;
    if (c >= CHAR_D0 && c <= CHAR_D9) begin
      v  = c - CHAR_D0;
      ok = 1'b1;
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      v  = c - (CHAR_UA - 8'd10);
      ok = 1'b1;
    end else if (c >= CHAR_LA && c <= CHAR_LF_HEX) begin
      v  = c - (CHAR_LA - 8'd10);
      ok = 1'b1;
    end
    return {ok, v[3:0]};
  endfunction

endpackage

[sv/cbls_in_stage.sv]
// input register stage holding one accepted byte transaction
module cbls_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  cbls_pkg::item_t item_i,
  input  logic           advance_i,
  output logic           valid_o,
  output cbls_pkg::item_t item_o
);
  import cbls_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  // stall only while a held byte cannot move on
  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load ? 1'b1 : (advance_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[sv/cbls_parser.sv]
// framing state and per-byte next-state logic of the chunked body scanner
module cbls_parser #(
  parameter int SIZE_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  cbls_pkg::item_t   item_i,
  output cbls_pkg::result_t result_o
);
  import cbls_pkg::*;

  localparam int SUMW = ((SIZE_BITS > 32) ? SIZE_BITS : 32) + 2;

  phase_e                phase_q, phase_d;
  logic [SIZE_BITS-1:0]  acc_q, acc_d;
  logic [31:0]           rem_q, rem_d;
  logic [31:0]           count_q, count_d;
  line_flags_t           flags_q, flags_d;
  logic                  bad_q, bad_d;
  verdict_e              verdict_q, verdict_d;

  phase_e                cur_phase;
  logic [SIZE_BITS-1:0]  cur_acc;
  logic [31:0]           cur_rem;
  logic [31:0]           cur_count;
  line_flags_t           cur_flags;
  logic                  cur_bad;
  verdict_e              cur_verdict;

  line_flags_t           f;
  logic                  b;
  logic [SIZE_BITS-1:0]  a;
  logic [7:0]            c;
  logic [4:0]            hex;
  logic                  is_blank;
  logic [SUMW-1:0]       acc_ext;
  logic                  len_ovf;

  assign c        = item_i.body_byte;
  assign hex      = hex_decode(c);
  assign is_blank = (c == CHAR_SP) || (c == CHAR_TAB);
  assign acc_ext  = SUMW'(cur_acc);
  // count after this lf, plus the data and its CR LF, must still fit in the byte count
  assign len_ovf  = (SUMW'(cur_count) + acc_ext + SUMW'(3)) > SUMW'(LEN_MAX);

  always_comb begin
    if (item_i.start_flag) begin
      cur_phase   = PH_SIZE;
      cur_acc     = '0;
      cur_rem     = '0;
      cur_count   = '0;
      cur_flags   = '0;
      cur_bad     = 1'b0;
      cur_verdict = V_MORE;
    end else begin
      cur_phase   = phase_q;
      cur_acc     = acc_q;
      cur_rem     = rem_q;
      cur_count   = count_q;
      cur_flags   = flags_q;
      cur_bad     = bad_q;
      cur_verdict = verdict_q;
    end

    phase_d   = cur_phase;
    acc_d     = cur_acc;
    rem_d     = cur_rem;
    count_d   = cur_count;
    flags_d   = cur_flags;
    bad_d     = cur_bad;
    verdict_d = cur_verdict;
    f         = cur_flags;
    b         = cur_bad;
    a         = cur_acc;

    if (cur_phase != PH_DONE) begin
      if (cur_count == LEN_MAX) begin
        verdict_d = V_BAD;
        phase_d   = PH_DONE;
      end else begin
        count_d = cur_count + 32'd1;
        case (cur_phase)
          PH_DATA: begin
            rem_d = cur_rem - 32'd1;
            if (cur_rem == 32'd1) begin
              phase_d = PH_DCR;
            end
          end
          PH_DCR: begin
            flags_d    = '0;
            flags_d.cr = (c == CHAR_CR);
            phase_d    = PH_DLF;
          end
          PH_DLF: begin
            if (cur_flags.cr && c == CHAR_LF) begin
              flags_d = '0;
              bad_d   = 1'b0;
              phase_d = PH_SIZE;
            end else begin
              verdict_d = V_BAD;
              phase_d   = PH_DONE;
            end
          end
          PH_SIZE, PH_TRAILER: begin
            if (cur_flags.cr && c == CHAR_LF) begin
              flags_d.cr = 1'b0;
              if (cur_phase == PH_SIZE) begin
                if (cur_bad || !cur_flags.digit) begin
                  verdict_d = V_BAD;
                  phase_d   = PH_DONE;
                end else begin
                  flags_d = '0;
                  bad_d   = 1'b0;
                  if (cur_acc == '0) begin
                    phase_d = PH_TRAILER;
                  end else if (len_ovf) begin
                    verdict_d = V_BAD;
                    phase_d   = PH_DONE;
                  end else begin
                    rem_d   = acc_ext[31:0];
                    acc_d   = '0;
                    phase_d = PH_DATA;
                  end
                end
              end else begin
                if (!cur_flags.nonempty) begin
                  verdict_d = V_DONE;
                  phase_d   = PH_DONE;
                end else if (!cur_flags.colon || cur_bad) begin
                  verdict_d = V_BAD;
                  phase_d   = PH_DONE;
                end else begin
                  flags_d = '0;
                  bad_d   = 1'b0;
                end
              end
            end else begin
              // a CR not followed by LF is an ordinary line byte
              if (f.cr) begin
                f.cr = 1'b0;
                if (cur_phase == PH_SIZE) begin
                  if (!f.ext) begin
                    b = 1'b1;
                  end
                end else begin
                  f.nonempty = 1'b1;
                end
              end
              if (c == CHAR_CR) begin
                f.cr = 1'b1;
              end else if (cur_phase == PH_SIZE) begin
                if (!f.ext) begin
                  if (is_blank) begin
                    if (f.digit) begin
                      f.tblank = 1'b1;
                    end
                  end else if (c == CHAR_SEMI) begin
                    f.ext = 1'b1;
                  end else if (!hex[4]) begin
                    b = 1'b1;
                  end else if (f.tblank) begin
                    b = 1'b1;
                  end else begin
                    f.digit = 1'b1;
                    if (!b) begin
                      if (a[SIZE_BITS-1 -: 4] != 4'd0) begin
                        b = 1'b1;
                      end else begin
                        a = {a[SIZE_BITS-5:0], hex[3:0]};
                      end
                    end
                  end
                end
              end else begin
                if (!f.nonempty && c == CHAR_COLON) begin
                  b = 1'b1;
                end
                f.nonempty = 1'b1;
                if (c == CHAR_COLON) begin
                  f.colon = 1'b1;
                end
              end
              flags_d = f;
              bad_d   = b;
              acc_d   = a;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SIZE;
      acc_q     <= '0;
      rem_q     <= '0;
      count_q   <= '0;
      flags_q   <= '0;
      bad_q     <= 1'b0;
      verdict_q <= V_MORE;
    end else if (step_i) begin
      phase_q   <= phase_d;
      acc_q     <= acc_d;
      rem_q     <= rem_d;
      count_q   <= count_d;
      flags_q   <= flags_d;
      bad_q     <= bad_d;
      verdict_q <= verdict_d;
    end
  end

  assign result_o.verdict      = verdict_d;
  assign result_o.total_length = (verdict_d == V_DONE) ? count_d : 32'd0;

  a_verdict_implies_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (verdict_q != V_MORE) |-> (phase_q == PH_DONE))
    else $error("final verdict held outside the done phase");

  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (rem_q != 32'd0))
    else $error("chunk data phase with nothing left to count");

  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA || phase_q == PH_DCR || phase_q == PH_DLF ||
     phase_q == PH_TRAILER) |-> (acc_q == '0))
    else $error("chunk size accumulator not cleared after size line");

endmodule

[sv/cbls_out_stage.sv]
// result register for the verdict and total length
module cbls_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  cbls_pkg::result_t result_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        verdict_o,
  output logic [31:0]       total_length_o
);
  import cbls_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign verdict_o      = result_q.verdict;
  assign total_length_o = result_q.total_length;

endmodule

[sv/chunked_body_length_scanner_core.sv]
// top level of the chunked message body length scanner
// an accepted byte is registered in the input stage, and its result in the output stage register
// throughput: one byte per cycle while the output is not stalled; the framing state updates once per scanned byte
// a result waiting downstream stops the input register from advancing, so the input stalls once it holds a byte
// reset: rst_ni clears all framing state to the size line phase with verdict need more
// start_flag on a byte clears the same state before that byte is scanned
module chunked_body_length_scanner_core #(
  parameter int SIZE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  body_byte_i,
  input  logic        start_flag_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  verdict_o,
  output logic [31:0] total_length_o
);
  import cbls_pkg::*;

  item_t   item_in;
  item_t   item_s1;
  logic    valid_s1;
  logic    ready_s2;
  result_t result_s2;

  assign item_in.body_byte  = body_byte_i;
  assign item_in.start_flag = start_flag_i;

  cbls_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item_in),
    .advance_i  (ready_s2),
    .valid_o    (valid_s1),
    .item_o     (item_s1)
  );

  cbls_parser #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (valid_s1 && ready_s2),
    .item_i   (item_s1),
    .result_o (result_s2)
  );

  cbls_out_stage u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (valid_s1),
    .result_i       (result_s2),
    .ready_o        (ready_s2),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .verdict_o      (verdict_o),
    .total_length_o (total_length_o)
  );

  a_stall_from_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (verdict_o == V_MORE || verdict_o == V_DONE || verdict_o == V_BAD))
    else $error("unused verdict code on output");

  a_length_only_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && verdict_o != V_DONE) |-> (total_length_o == 32'd0))
    else $error("total length reported without a complete verdict");

  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_s1 && ready_s2) |=> out_valid_o)
    else $error("scanned byte produced no result transaction");

endmodule
